### sv/quad_dac_command_decoder_assert.svh
// Assertion macros used by the FIFO RTL file.
`ifndef QUAD_DAC_COMMAND_DECODER_ASSERT_SVH
`define QUAD_DAC_COMMAND_DECODER_ASSERT_SVH

// The condition must never hold while out of reset.
`define QDCD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("assertion failed: condition must never hold");

// The antecedent implies the consequent in the same cycle.
`define QDCD_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// The antecedent implies the consequent in the next cycle.
`define QDCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`endif

### sv/qdcd_pkg.sv
`timescale 1ns / 1ps
package qdcd_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned FifoDepth   = 4;

  localparam logic [7:0] KIND_MASK  = 8'hE0;
  localparam logic [7:0] KIND_CHAN  = 8'h40;
  localparam logic [7:0] KIND_REF   = 8'h80;
  localparam logic [7:0] KIND_PD    = 8'hA0;
  localparam logic [7:0] KIND_GAIN  = 8'hC0;

  localparam logic [7:0] SUB_MASK   = 8'h18;
  localparam logic [7:0] SUB_MULTI  = 8'h00;
  localparam logic [7:0] SUB_SEQ    = 8'h10;
  localparam logic [7:0] SUB_SINGLE = 8'h18;

  localparam logic [12:0] INT_REF_MV = 13'd2048;

  // Snapshot of one channel, taken when its result is queued.
  typedef struct packed {
    logic [1:0]  channel;
    logic [11:0] code;
    logic [3:0]  cfg;
    logic [11:0] nv_code;
    logic [3:0]  nv_cfg;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### sv/quad_dac_command_decoder.sv
`timescale 1ns / 1ps
// Command decoder for a four-channel 12-bit DAC.
// The slave stream takes the write bytes of bus transactions, one per request;
// tuser marks the command byte that opens a transaction. The master stream
// returns one request per updated channel with its volatile and EEPROM shadows
// and its output in millivolts; tlast marks the final result of an input byte.
// ext_ref_mv_i is loaded whenever ext_ref_mv_we_i is high; write it only while
// the block is idle.
// A result is registered in the front decoder, the queue, the product stage and the output register in turn.
// Throughput: one byte per cycle while the queue is not full, when a byte causes
// at most one result; a broadcast or power-down byte causes four results, queued
// one per cycle while the queue has room, and the slave side holds off until the
// last of them is being queued.
// The front decoder and the result path are joined by a four-entry queue, and
// the result path ends in an output register, so a stalled receiver blocks
// input only once the queue is full.
// Reset clears all shadows and the decoder state, and sets the external
// reference to 3300 mV.
module quad_dac_command_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ext_ref_mv_we_i,
  input  logic [12:0] ext_ref_mv_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data
  input  logic        s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] channel, [13:2] code, [14] ref_internal, [16:15] power_mode,
  // [17] gain_bit, [19:18] eff_gain, [31:20] nv_code, [35:32] nv_config,
  // [48:36] out_mv, [55:49] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic                 push;
  logic                 pop;
  qdcd_pkg::entry_t     push_entry;
  qdcd_pkg::entry_t     head_entry;
  qdcd_pkg::fifo_stat_t stat;

  qdcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .stat_i        (stat),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  qdcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (stat)
  );

  qdcd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ext_ref_mv_we_i (ext_ref_mv_we_i),
    .ext_ref_mv_i    (ext_ref_mv_i),
    .entry_i         (head_entry),
    .stat_i          (stat),
    .pop_o           (pop),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast)
  );

endmodule

### sv/qdcd_front.sv
`timescale 1ns / 1ps
module qdcd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data
  input  logic                s_axis_tuser,   // [0] first
  input  qdcd_pkg::fifo_stat_t stat_i,
  output logic                push_o,
  output qdcd_pkg::entry_t    entry_o
);

  logic [3:0]  vol_cfg_q  [qdcd_pkg::NumChannels];
  logic [3:0]  vol_cfg_d  [qdcd_pkg::NumChannels];
  logic [11:0] vol_code_q [qdcd_pkg::NumChannels];
  logic [11:0] vol_code_d [qdcd_pkg::NumChannels];
  logic [3:0]  nv_cfg_q   [qdcd_pkg::NumChannels];
  logic [3:0]  nv_cfg_d   [qdcd_pkg::NumChannels];
  logic [11:0] nv_code_q  [qdcd_pkg::NumChannels];
  logic [11:0] nv_code_d  [qdcd_pkg::NumChannels];

  logic [7:0] cmd_q, cmd_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] held_q, held_d;
  logic [2:0] chan_q, chan_d;
  logic [2:0] emit_left_q, emit_left_d;
  logic [1:0] emit_ch_q, emit_ch_d;

  logic accept;

  assign push_o        = (emit_left_q != 3'd0) && !stat_i.full;
  assign s_axis_tready = (emit_left_q == 3'd0) || ((emit_left_q == 3'd1) && !stat_i.full);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    entry_o.channel = emit_ch_q;
    entry_o.code    = vol_code_q[emit_ch_q];
    entry_o.cfg     = vol_cfg_q[emit_ch_q];
    entry_o.nv_code = nv_code_q[emit_ch_q];
    entry_o.nv_cfg  = nv_cfg_q[emit_ch_q];
    entry_o.last    = (emit_left_q == 3'd1);
  end

  always_comb begin
    logic [7:0] kind;
    logic [7:0] sub;
    logic [7:0] pd_bits;
    logic       first;
    logic       wr_en;
    logic       wr_nv;
    logic [1:0] wr_ch;
    logic [7:0] wr_cfg;

    vol_cfg_d  = vol_cfg_q;
    vol_code_d = vol_code_q;
    nv_cfg_d   = nv_cfg_q;
    nv_code_d  = nv_code_q;
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    held_d     = held_q;
    chan_d     = chan_q;
    first      = s_axis_tuser;
    wr_en      = 1'b0;
    wr_nv      = 1'b0;
    wr_ch      = chan_q[1:0];
    wr_cfg     = held_q;

    emit_left_d = emit_left_q;
    emit_ch_d   = emit_ch_q;
    if (push_o) begin
      emit_left_d = emit_left_q - 3'd1;
      emit_ch_d   = emit_ch_q + 2'd1;
    end

    if (accept && first) begin
      cmd_d  = s_axis_tdata;
      cnt_d  = 2'd0;
      held_d = 8'd0;
      chan_d = {1'b0, s_axis_tdata[2:1]};
    end

    kind    = cmd_d & qdcd_pkg::KIND_MASK;
    sub     = cmd_d & qdcd_pkg::SUB_MASK;
    pd_bits = {cmd_d[3:0], s_axis_tdata[7:4]};

    if (accept) begin
      unique case (kind) inside
        qdcd_pkg::KIND_CHAN: begin
          case (sub) inside
            qdcd_pkg::SUB_MULTI, qdcd_pkg::SUB_SINGLE: begin
              if (first) begin
                cnt_d = 2'd1;
              end else if (cnt_d == 2'd0) begin
                chan_d = {1'b0, s_axis_tdata[2:1]};
                cnt_d  = 2'd1;
              end else if (cnt_d == 2'd1) begin
                held_d = s_axis_tdata;
                cnt_d  = 2'd2;
              end else begin
                wr_en       = 1'b1;
                wr_nv       = (sub == qdcd_pkg::SUB_SINGLE);
                wr_ch       = chan_d[1:0];
                wr_cfg      = held_d;
                emit_left_d = 3'd1;
                emit_ch_d   = chan_d[1:0];
                cnt_d       = 2'd0;
              end
            end
            qdcd_pkg::SUB_SEQ: begin
              // Pairs beyond the last channel are dropped.
              if (!first && !chan_d[2]) begin
                if (cnt_d == 2'd0) begin
                  held_d = s_axis_tdata;
                  cnt_d  = 2'd1;
                end else begin
                  wr_en       = 1'b1;
                  wr_nv       = 1'b1;
                  wr_ch       = chan_d[1:0];
                  wr_cfg      = held_d;
                  emit_left_d = 3'd1;
                  emit_ch_d   = chan_d[1:0];
                  chan_d      = chan_d + 3'd1;
                  cnt_d       = 2'd0;
                end
              end
            end
            default: ;
          endcase
        end
        qdcd_pkg::KIND_REF, qdcd_pkg::KIND_GAIN: begin
          if (first) begin
            for (int i = 0; i < qdcd_pkg::NumChannels; i++) begin
              if (kind == qdcd_pkg::KIND_REF) begin
                vol_cfg_d[i][3] = s_axis_tdata[3-i];
              end else begin
                vol_cfg_d[i][0] = s_axis_tdata[3-i];
              end
            end
            emit_left_d = 3'd4;
            emit_ch_d   = 2'd0;
          end
        end
        qdcd_pkg::KIND_PD: begin
          if (!first && cnt_d == 2'd0) begin
            for (int i = 0; i < qdcd_pkg::NumChannels; i++) begin
              vol_cfg_d[i][2:1] = pd_bits[(3-i)*2 +: 2];
            end
            emit_left_d = 3'd4;
            emit_ch_d   = 2'd0;
            cnt_d       = 2'd1;
          end
        end
        default: ;
      endcase
    end

    if (wr_en) begin
      vol_cfg_d[wr_ch]  = wr_cfg[7:4];
      vol_code_d[wr_ch] = {wr_cfg[3:0], s_axis_tdata};
      if (wr_nv) begin
        nv_cfg_d[wr_ch]  = wr_cfg[7:4];
        nv_code_d[wr_ch] = {wr_cfg[3:0], s_axis_tdata};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qdcd_pkg::NumChannels; i++) begin
        vol_cfg_q[i]  <= 4'd0;
        vol_code_q[i] <= 12'd0;
        nv_cfg_q[i]   <= 4'd0;
        nv_code_q[i]  <= 12'd0;
      end
      cmd_q       <= 8'd0;
      cnt_q       <= 2'd0;
      held_q      <= 8'd0;
      chan_q      <= 3'd0;
      emit_left_q <= 3'd0;
      emit_ch_q   <= 2'd0;
    end else begin
      vol_cfg_q   <= vol_cfg_d;
      vol_code_q  <= vol_code_d;
      nv_cfg_q    <= nv_cfg_d;
      nv_code_q   <= nv_code_d;
      cmd_q       <= cmd_d;
      cnt_q       <= cnt_d;
      held_q      <= held_d;
      chan_q      <= chan_d;
      emit_left_q <= emit_left_d;
      emit_ch_q   <= emit_ch_d;
    end
  end

endmodule

### sv/qdcd_fifo.sv
`timescale 1ns / 1ps
`include "quad_dac_command_decoder_assert.svh"
module qdcd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  qdcd_pkg::entry_t     entry_i,
  input  logic                 pop_i,
  output qdcd_pkg::entry_t     entry_o,
  output qdcd_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(qdcd_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(qdcd_pkg::FifoDepth + 1);

  qdcd_pkg::entry_t mem_q [qdcd_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == CntW'(qdcd_pkg::FifoDepth));
  assign stat_o.empty = (count_q == '0);
  assign entry_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `QDCD_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && stat_o.full)
  `QDCD_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && stat_o.empty)
  `QDCD_ASSERT_IMPLIES(a_ptrs_match, clk_i, rst_ni, stat_o.empty, wr_ptr_q == rd_ptr_q)
  `QDCD_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, push_i && !pop_i, count_q != '0)

endmodule

### sv/qdcd_back.sv
`timescale 1ns / 1ps
module qdcd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ext_ref_mv_we_i,
  input  logic [12:0]          ext_ref_mv_i,
  input  qdcd_pkg::entry_t     entry_i,
  input  qdcd_pkg::fifo_stat_t stat_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [55:0]          m_axis_tdata,
  output logic                 m_axis_tlast
);

  logic [12:0] ext_ref_q;
  logic [12:0] ref_mv;
  logic [24:0] prod;

  logic             s1_valid_q;
  qdcd_pkg::entry_t s1_entry_q;
  logic [24:0]      s1_prod_q;

  logic        out_valid_q;
  logic [55:0] out_data_q;
  logic        out_last_q;
  logic [55:0] out_data_d;

  logic out_adv;
  logic s1_adv;

  assign out_adv = !out_valid_q || m_axis_tready;
  assign s1_adv  = !s1_valid_q || out_adv;
  assign pop_o   = !stat_i.empty && s1_adv;

  // Internal reference doubles when its gain bit is set; external ignores gain.
  always_comb begin
    if (entry_i.cfg[3]) begin
      ref_mv = entry_i.cfg[0] ? (qdcd_pkg::INT_REF_MV << 1) : qdcd_pkg::INT_REF_MV;
    end else begin
      ref_mv = ext_ref_q;
    end
    prod = 25'(entry_i.code) * 25'(ref_mv);
  end

  always_comb begin
    logic [12:0] mv;
    logic [1:0]  eg;
    mv = (s1_entry_q.cfg[2:1] == 2'd0) ? s1_prod_q[24:12] : 13'd0;
    eg = (s1_entry_q.cfg[3] && s1_entry_q.cfg[0]) ? 2'd2 : 2'd1;
    out_data_d = {7'd0, mv, s1_entry_q.nv_cfg, s1_entry_q.nv_code, eg,
                  s1_entry_q.cfg[0], s1_entry_q.cfg[2:1], s1_entry_q.cfg[3],
                  s1_entry_q.code, s1_entry_q.channel};
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_entry_q <= entry_i;
      s1_prod_q  <= prod;
    end
    if (out_adv && s1_valid_q) begin
      out_data_q <= out_data_d;
      out_last_q <= s1_entry_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_ref_q   <= 13'd3300;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ext_ref_mv_we_i) begin
        ext_ref_q <= ext_ref_mv_i;
      end
      if (s1_adv) begin
        s1_valid_q <= pop_o;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

  // Command groups that the decoder ignores.
  localparam logic [7:0] KIND_FAST  = 8'h00;
  localparam logic [7:0] KIND_ADDR  = 8'h60;
  localparam logic [7:0] KIND_TOP   = 8'hE0;
  localparam logic [7:0] SUB_UNUSED = 8'h08;

  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 40;

  typedef struct packed {
    logic [1:0]  channel;
    logic [11:0] code;
    logic        ref_internal;
    logic [1:0]  power_mode;
    logic        gain_bit;
    logic [1:0]  eff_gain;
    logic [11:0] nv_code;
    logic [3:0]  nv_config;
    logic [12:0] out_mv;
    logic        last;
  } dac_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        ext_ref_mv_we_i;
  logic [12:0] ext_ref_mv_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Mirror of the decoder state.
  logic [3:0]  vol_cfg [qdcd_pkg::NumChannels];
  logic [11:0] vol_code [qdcd_pkg::NumChannels];
  logic [3:0]  eeprom_cfg [qdcd_pkg::NumChannels];
  logic [11:0] eeprom_code [qdcd_pkg::NumChannels];
  logic [7:0]  active_cmd;
  logic [3:0]  byte_pos;
  logic [7:0]  cfg_hold;
  logic [2:0]  write_ch;
  logic [12:0] ext_ref_mv;

  dac_result_t pending_updates[$];
  dac_result_t want;
  int          fail_count;
  int          cycle_count;
  bit          tx_idle;
  bit          rx_idle;

  quad_dac_command_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ext_ref_mv_we_i (ext_ref_mv_we_i),
    .ext_ref_mv_i    (ext_ref_mv_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic dac_result_t snapshot_channel(input int ch);
    dac_result_t r;
    int unsigned ref_mv;
    r = '0;
    r.channel      = ch[1:0];
    r.code         = vol_code[ch];
    r.ref_internal = vol_cfg[ch][3];
    r.power_mode   = vol_cfg[ch][2:1];
    r.gain_bit     = vol_cfg[ch][0];
    r.eff_gain     = (r.ref_internal && r.gain_bit) ? 2'd2 : 2'd1;
    r.nv_code      = eeprom_code[ch];
    r.nv_config    = eeprom_cfg[ch];
    ref_mv = r.ref_internal ? int'(qdcd_pkg::INT_REF_MV) * int'(r.eff_gain)
                            : int'(ext_ref_mv);
    if (r.power_mode == 2'd0) r.out_mv = 13'((int'(r.code) * ref_mv) >> 12);
    return r;
  endfunction

  function automatic void load_channel(input logic [1:0] ch, input logic [7:0] cfg_byte,
                                       input logic [7:0] lo, input bit to_eeprom);
    vol_cfg[ch]  = cfg_byte[7:4];
    vol_code[ch] = {cfg_byte[3:0], lo};
    if (to_eeprom) begin
      eeprom_cfg[ch]  = vol_cfg[ch];
      eeprom_code[ch] = vol_code[ch];
    end
  endfunction

  // Advances the mirror by one accepted byte and queues the channel updates it causes.
  task automatic decode_write_byte(input logic [7:0] d, input logic is_first);
    dac_result_t upd[$];
    dac_result_t r;
    logic [7:0]  kind;
    logic [7:0]  sub;
    logic [7:0]  pd_bits;
    if (is_first) begin
      active_cmd = d;
      byte_pos   = 4'd0;
      cfg_hold   = 8'd0;
      write_ch   = {1'b0, d[2:1]};
    end
    kind = active_cmd & qdcd_pkg::KIND_MASK;
    sub  = active_cmd & qdcd_pkg::SUB_MASK;
    if (kind == qdcd_pkg::KIND_CHAN) begin
      if (sub == qdcd_pkg::SUB_MULTI || sub == qdcd_pkg::SUB_SINGLE) begin
        if (is_first) begin
          byte_pos = 4'd1;
        end else if (byte_pos == 4'd0) begin
          write_ch = {1'b0, d[2:1]};
          byte_pos = 4'd1;
        end else if (byte_pos == 4'd1) begin
          cfg_hold = d;
          byte_pos = 4'd2;
        end else begin
          load_channel(write_ch[1:0], cfg_hold, d, sub == qdcd_pkg::SUB_SINGLE);
          upd.push_back(snapshot_channel(write_ch[1:0]));
          byte_pos = 4'd0;
        end
      end else if (sub == qdcd_pkg::SUB_SEQ && !is_first &&
                   write_ch < qdcd_pkg::NumChannels) begin
        if (byte_pos == 4'd0) begin
          cfg_hold = d;
          byte_pos = 4'd1;
        end else begin
          load_channel(write_ch[1:0], cfg_hold, d, 1'b1);
          upd.push_back(snapshot_channel(write_ch[1:0]));
          write_ch = write_ch + 3'd1;
          byte_pos = 4'd0;
        end
      end
    end else if (kind == qdcd_pkg::KIND_REF || kind == qdcd_pkg::KIND_GAIN) begin
      if (is_first) begin
        for (int i = 0; i < qdcd_pkg::NumChannels; i++) begin
          if (kind == qdcd_pkg::KIND_REF) vol_cfg[i][3] = d[3-i];
          else vol_cfg[i][0] = d[3-i];
          upd.push_back(snapshot_channel(i));
        end
      end
    end else if (kind == qdcd_pkg::KIND_PD) begin
      if (!is_first && byte_pos == 4'd0) begin
        pd_bits = {active_cmd[3:0], d[7:4]};
        for (int i = 0; i < qdcd_pkg::NumChannels; i++) begin
          vol_cfg[i][2:1] = pd_bits[7-2*i -: 2];
          upd.push_back(snapshot_channel(i));
        end
        byte_pos = 4'd1;
      end
    end
    foreach (upd[k]) begin
      r = upd[k];
      r.last = (k == upd.size() - 1);
      pending_updates.push_back(r);
    end
  endtask

  task automatic send_byte(input logic [7:0] d, input logic is_first);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= is_first;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_write_byte(d, is_first);
  endtask

  // A command byte followed by random payload bytes.
  task automatic send_run(input logic [7:0] cmd, input int nbytes);
    send_byte(cmd, 1'b1);
    for (int k = 1; k < nbytes; k++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ext_ref(input logic [12:0] mv);
    @(negedge clk_i);
    ext_ref_mv_we_i <= 1'b1;
    ext_ref_mv_i    <= mv;
    @(negedge clk_i);
    ext_ref_mv_we_i <= 1'b0;
    ext_ref_mv      = mv;
  endtask

  // Receiver: stalls a random number of cycles before each result while rx_idle is set.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = rx_idle ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_updates.size() == 0) begin
        $error("result for channel %0d with none expected", m_axis_tdata[1:0]);
        fail_count++;
      end else begin
        want = pending_updates.pop_front();
        check_field("channel", want.channel, m_axis_tdata[1:0]);
        check_field("code", want.code, m_axis_tdata[13:2]);
        check_field("ref_internal", want.ref_internal, m_axis_tdata[14]);
        check_field("power_mode", want.power_mode, m_axis_tdata[16:15]);
        check_field("gain_bit", want.gain_bit, m_axis_tdata[17]);
        check_field("eff_gain", want.eff_gain, m_axis_tdata[19:18]);
        check_field("nv_code", want.nv_code, m_axis_tdata[31:20]);
        check_field("nv_config", want.nv_config, m_axis_tdata[35:32]);
        check_field("out_mv", want.out_mv, m_axis_tdata[48:36]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  // A stray byte before any command, then fast, address, top and unused-sub-command bytes.
  task automatic test_ignored_commands();
    send_byte(8'hFF, 1'b0);
    send_byte(KIND_FAST | 8'h1F, 1'b1);
    send_byte(KIND_ADDR | 8'h0C, 1'b1);
    send_byte(KIND_TOP | 8'h0F, 1'b1);
    send_byte(qdcd_pkg::KIND_CHAN | SUB_UNUSED | 8'h02, 1'b1);
  endtask

  // Two triples; the second takes its channel from its own leading byte.
  task automatic test_multi_write();
    send_byte(qdcd_pkg::KIND_CHAN | qdcd_pkg::SUB_MULTI, 1'b1);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'hF9, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_single_write();
    send_byte(qdcd_pkg::KIND_CHAN | qdcd_pkg::SUB_SINGLE | 8'h03, 1'b1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h23, 1'b0);
  endtask

  // Starts at channel 2; the pair after channel 3 must be dropped.
  task automatic test_sequential_write();
    send_byte(qdcd_pkg::KIND_CHAN | qdcd_pkg::SUB_SEQ | 8'h04, 1'b1);
    send_byte(8'h91, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'hBC, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
  endtask

  task automatic test_broadcast();
    send_byte(qdcd_pkg::KIND_REF | 8'h0A, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(qdcd_pkg::KIND_GAIN | 8'h15, 1'b1);
  endtask

  // A full power-down pair with a trailing byte, then one cut short.
  task automatic test_power_down();
    send_byte(qdcd_pkg::KIND_PD | 8'h05, 1'b1);
    send_byte(8'h60, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(qdcd_pkg::KIND_PD | 8'h03, 1'b1);
  endtask

  task automatic random_transaction(output int useful);
    int pick;
    int nbytes;
    int sel;
    logic [7:0] cmd;
    useful = 0;
    pick = $urandom_range(0, 19);
    if (pick < 7) begin
      cmd = qdcd_pkg::KIND_CHAN
          | ((pick < 4) ? qdcd_pkg::SUB_MULTI : qdcd_pkg::SUB_SINGLE)
          | 8'($urandom & 8'h07);
      nbytes = 3 * $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) nbytes -= $urandom_range(1, 2);
      send_run(cmd, nbytes);
      useful = nbytes;
    end else if (pick < 11) begin
      nbytes = 1 + 2 * $urandom_range(1, 5);
      if ($urandom_range(0, 9) == 0) nbytes -= 1;
      send_run(qdcd_pkg::KIND_CHAN | qdcd_pkg::SUB_SEQ | 8'($urandom & 8'h07), nbytes);
      useful = nbytes;
    end else if (pick < 15) begin
      cmd = ((pick < 13) ? qdcd_pkg::KIND_REF : qdcd_pkg::KIND_GAIN)
          | 8'($urandom & 8'h1F);
      send_run(cmd, 1 + $urandom_range(0, 2));
      useful = 1;
    end else if (pick < 18) begin
      nbytes = 1 + $urandom_range(0, 3);
      send_run(qdcd_pkg::KIND_PD | 8'($urandom & 8'h1F), nbytes);
      useful = (nbytes > 1) ? 2 : 1;
    end else if (pick == 18) begin
      sel = $urandom_range(0, 3);
      case (sel)
        0: cmd = KIND_FAST | 8'($urandom & 8'h1F);
        1: cmd = KIND_ADDR | 8'($urandom & 8'h1F);
        2: cmd = KIND_TOP | 8'($urandom & 8'h1F);
        default: cmd = qdcd_pkg::KIND_CHAN | SUB_UNUSED | 8'($urandom & 8'h07);
      endcase
      send_run(cmd, 1 + $urandom_range(0, 3));
    end else begin
      send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // Several reference settings, the extremes among them, each in its own phase.
  task automatic test_random();
    logic [12:0] settings [5];
    int done;
    int useful;
    settings[0] = 13'd5500;
    settings[1] = 13'd0;
    settings[2] = 13'($urandom_range(1, 5499));
    settings[3] = 13'd2048;
    settings[4] = 13'($urandom_range(0, 5500));
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_ext_ref(settings[p]);
      tx_idle = (p != 1);
      rx_idle = (p != 1 && p != 3);
      done = 0;
      while (done < PHASE_ITEMS) begin
        random_transaction(useful);
        done += useful;
        if ($urandom_range(0, 15) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    ext_ref_mv_we_i = 1'b0;
    ext_ref_mv_i    = 13'd0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'd0;
    s_axis_tuser    = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    for (int i = 0; i < qdcd_pkg::NumChannels; i++) begin
      vol_cfg[i]     = '0;
      vol_code[i]    = '0;
      eeprom_cfg[i]  = '0;
      eeprom_code[i] = '0;
    end
    active_cmd = '0;
    byte_pos   = '0;
    cfg_hold   = '0;
    write_ch   = '0;
    ext_ref_mv = 13'd3300;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_commands();
    test_multi_write();
    test_single_write();
    test_sequential_write();
    test_broadcast();
    test_power_down();
    test_random();
    wait_drained();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### quad_dac_command_decoder.f
+incdir+sv
sv/qdcd_pkg.sv
sv/qdcd_front.sv
sv/qdcd_fifo.sv
sv/qdcd_back.sv
sv/quad_dac_command_decoder.sv
sim/testbench.sv
